// ===== rtl/bip_pkg.sv =====
`timescale 1ns / 1ps

package bip_pkg;

  // fixed field widths
  localparam int unsigned OPCODE_W  = 1;
  localparam int unsigned SET_W     = 11;
  localparam int unsigned WAY_W     = 4;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned PERIOD_W  = 8;

  // defaults for the top level parameters
  localparam int unsigned SETS_DEF       = 2048;
  localparam int unsigned WAYS_DEF       = 16;
  localparam int unsigned STAMP_BITS_DEF = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd20;

  // set index reduction: quotient estimate by reciprocal, shift > SET_W
  localparam int unsigned MOD_SHIFT = SET_W + 1;
  localparam int unsigned RECIP_W   = MOD_SHIFT + 1;
  localparam int unsigned PROD_W    = SET_W + RECIP_W;
  localparam int unsigned QUOT_W    = PROD_W - MOD_SHIFT;
  localparam int unsigned REM_W     = 17;

  typedef enum logic [OPCODE_W-1:0] {
    OPC_VICTIM = 1'b0,
    OPC_UPDATE = 1'b1
  } opcode_e;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_QUOT  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_TREE  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

// ===== rtl/bip_min_tree.sv =====
`timescale 1ns / 1ps

module bip_min_tree import bip_pkg::*; #(
  parameter int unsigned WAYS       = WAYS_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic [WAYS*STAMP_BITS-1:0]         row_i,
  output logic [$clog2(WAYS)-1:0]            min_way_o,
  output logic [STAMP_BITS-1:0]              min_stamp_o
);

  localparam int unsigned WW  = $clog2(WAYS);
  localparam int unsigned LVL = WW;
  localparam int unsigned P   = 1 << WW;
  localparam int unsigned SB  = STAMP_BITS;

  logic [SB-1:0] leaf_st  [P];
  logic [WW-1:0] leaf_way [P];

  // padding leaves carry the largest stamp and the highest index, so a real way wins
  always_comb begin
    for (int i = 0; i < P; i++) begin
      if (i < WAYS) begin
        leaf_st[i] = row_i[i*SB +: SB];
      end else begin
        leaf_st[i] = '1;
      end
      leaf_way[i] = WW'(i);
    end
  end

  logic [SB-1:0] lv_st_q  [LVL][P/2];
  logic [WW-1:0] lv_way_q [LVL][P/2];

  // left child wins a tie: its indices are all lower
  always_ff @(posedge clk_i) begin
    for (int n = 0; n < P/2; n++) begin
      if (leaf_st[2*n+1] < leaf_st[2*n]) begin
        lv_st_q[0][n]  <= leaf_st[2*n+1];
        lv_way_q[0][n] <= leaf_way[2*n+1];
      end else begin
        lv_st_q[0][n]  <= leaf_st[2*n];
        lv_way_q[0][n] <= leaf_way[2*n];
      end
    end
    for (int l = 1; l < LVL; l++) begin
      for (int n = 0; n < P/2; n++) begin
        if (n < (P >> (l + 1))) begin
          if (lv_st_q[l-1][2*n+1] < lv_st_q[l-1][2*n]) begin
            lv_st_q[l][n]  <= lv_st_q[l-1][2*n+1];
            lv_way_q[l][n] <= lv_way_q[l-1][2*n+1];
          end else begin
            lv_st_q[l][n]  <= lv_st_q[l-1][2*n];
            lv_way_q[l][n] <= lv_way_q[l-1][2*n];
          end
        end else begin
          lv_st_q[l][n]  <= '0;
          lv_way_q[l][n] <= '0;
        end
      end
    end
  end

  assign min_way_o   = lv_way_q[LVL-1][0];
  assign min_stamp_o = lv_st_q[LVL-1][0];

endmodule

// ===== rtl/bimodal_insertion_replacement_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                                         Transfer
// request   in         start, opcode_i, set_index_i, way_index_i,      start & !busy
//                      was_hit_i, now_i
// victim    out        victim_valid_o, victim_way_o                    victim_valid_o, 1 cycle
// config    in         insert_period_we_i, insert_period_i             insert_period_we_i
//
// One request at a time: busy stays high after the transfer through the set
// reduction, the row read, each level of the minimum tree and the final write back
// or victim step, so a new request is taken only once the last one is through.
// The victim strobe rises in the same cycle busy falls; the receiver cannot stall.
// After reset a clearing pass zeroes the stamp memory one set per cycle, with busy
// high until every set is cleared; configuration writes are taken meanwhile.

module bimodal_insertion_replacement_core import bip_pkg::*; #(
  parameter int unsigned SETS       = SETS_DEF,
  parameter int unsigned WAYS       = WAYS_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [SET_W-1:0]    set_index_i,
  input  logic [WAY_W-1:0]    way_index_i,
  input  logic                was_hit_i,
  input  logic [NOW_W-1:0]    now_i,
  output logic                victim_valid_o,
  output logic [WAY_W-1:0]    victim_way_o,
  input  logic                insert_period_we_i,
  input  logic [PERIOD_W-1:0] insert_period_i
);

  localparam int unsigned SB    = STAMP_BITS;
  localparam int unsigned WW    = $clog2(WAYS);
  localparam int unsigned LVL   = WW;
  localparam int unsigned ROW_W = WAYS * SB;
  localparam int unsigned SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned CW    = $clog2(LVL + 1);

  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((1 << MOD_SHIFT) / SETS);
  localparam logic [REM_W-1:0]   SETS_R = REM_W'(SETS);
  localparam logic [5:0]         WAYS_C = 6'(WAYS);

  state_e state_q, state_d;

  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] residue_q, residue_d;
  logic [SW-1:0]       clr_q, clr_d;
  logic [CW-1:0]       lvl_cnt_q, lvl_cnt_d;
  logic                valid_q, valid_d;
  logic [WAY_W-1:0]    vway_q, vway_d;

  logic                op_q;
  logic [SET_W-1:0]    set_q;
  logic [WAY_W-1:0]    way_q;
  logic                hit_q;
  logic [SB-1:0]       now_q;
  logic [QUOT_W-1:0]   quot_q;
  logic [SW-1:0]       row_q;

  logic [ROW_W-1:0]    mem [SETS];
  logic [ROW_W-1:0]    rd_data_q;
  logic                mem_re, mem_we;
  logic [SW-1:0]       mem_wa;
  logic [ROW_W-1:0]    mem_wd;

  logic [PROD_W-1:0]   prod;
  logic [REM_W-1:0]    rem_est, rem_fix;
  logic [SW-1:0]       row_sel;

  logic [WW-1:0]       min_way;
  logic [SB-1:0]       min_stamp;

  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W:0]   res_next;
  logic                wrap, mru, way_ok;
  logic [SB-1:0]       new_stamp;
  logic [ROW_W-1:0]    wb_row;

  assign busy = (state_q != ST_IDLE);

  // set_index mod SETS: quotient estimate is exact or one short
  assign prod    = PROD_W'(set_q) * PROD_W'(RECIP);
  assign rem_est = REM_W'(set_q) - REM_W'(quot_q * SETS_R);
  assign rem_fix = (rem_est >= SETS_R) ? (rem_est - SETS_R) : rem_est;
  assign row_sel = SW'(rem_fix);

  bip_min_tree #(
    .WAYS       (WAYS),
    .STAMP_BITS (STAMP_BITS)
  ) u_min_tree (
    .clk_i       (clk_i),
    .row_i       (rd_data_q),
    .min_way_o   (min_way),
    .min_stamp_o (min_stamp)
  );

  // insertion decision and write-back row
  always_comb begin
    period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
    res_next   = {1'b0, residue_q} + (PERIOD_W+1)'(1);
    wrap       = (res_next >= {1'b0, period_eff});
    mru        = hit_q | wrap;
    way_ok     = ({2'b00, way_q} < WAYS_C);
    if (mru) begin
      new_stamp = now_q;
    end else if (min_stamp == '0) begin
      new_stamp = '0;
    end else begin
      new_stamp = min_stamp - SB'(1);
    end
    wb_row = rd_data_q;
    for (int w = 0; w < WAYS; w++) begin
      if (way_ok && ({2'b00, way_q} == 6'(w))) begin
        wb_row[w*SB +: SB] = new_stamp;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    residue_d = residue_q;
    clr_d     = clr_q;
    lvl_cnt_d = lvl_cnt_q;
    valid_d   = 1'b0;
    vway_d    = vway_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = row_q;
    mem_wd    = wb_row;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + SW'(1);
        if (clr_q == SW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_QUOT;
        end
      end
      ST_QUOT: begin
        state_d = ST_READ;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        lvl_cnt_d = '0;
        state_d   = ST_TREE;
      end
      ST_TREE: begin
        lvl_cnt_d = lvl_cnt_q + CW'(1);
        if (lvl_cnt_q == CW'(LVL - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
        if (op_q == OPC_VICTIM) begin
          valid_d = 1'b1;
          vway_d  = WAY_W'(min_way);
        end else begin
          mem_we = way_ok;
          if (!hit_q) begin
            residue_d = wrap ? '0 : res_next[PERIOD_W-1:0];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      period_q  <= PERIOD_RESET;
      residue_q <= '0;
      clr_q     <= '0;
      lvl_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      residue_q <= residue_d;
      clr_q     <= clr_d;
      lvl_cnt_q <= lvl_cnt_d;
      valid_q   <= valid_d;
      if (insert_period_we_i) begin
        period_q <= insert_period_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vway_q <= vway_d;
    if (state_q == ST_IDLE && start) begin
      op_q  <= opcode_i;
      set_q <= set_index_i;
      way_q <= way_index_i;
      hit_q <= was_hit_i;
      now_q <= SB'(now_i);
    end
    if (state_q == ST_QUOT) begin
      quot_q <= prod[PROD_W-1:MOD_SHIFT];
    end
    if (state_q == ST_READ) begin
      row_q <= row_sel;
    end
  end

  // stamp memory, one row per set
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[row_sel];
    end
  end

  assign victim_valid_o = valid_q;
  assign victim_way_o   = vway_q;

endmodule

// ===== dv/bimodal_insertion_replacement_core_tb.sv =====
`timescale 1ns / 1ps

module bimodal_insertion_replacement_core_tb;
  import bip_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 12;     // busy window plus strobe, with margin
  localparam int unsigned DRAIN_LIMIT   = 10000;  // covers the clearing pass after reset
  localparam int unsigned HOT_SETS      = 6;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [OPCODE_W-1:0] opcode_i;
  logic [SET_W-1:0]    set_index_i;
  logic [WAY_W-1:0]    way_index_i;
  logic                was_hit_i;
  logic [NOW_W-1:0]    now_i;
  logic                victim_valid_o;
  logic [WAY_W-1:0]    victim_way_o;
  logic                insert_period_we_i;
  logic [PERIOD_W-1:0] insert_period_i;

  bimodal_insertion_replacement_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .set_index_i        (set_index_i),
    .way_index_i        (way_index_i),
    .was_hit_i          (was_hit_i),
    .now_i              (now_i),
    .victim_valid_o     (victim_valid_o),
    .victim_way_o       (victim_way_o),
    .insert_period_we_i (insert_period_we_i),
    .insert_period_i    (insert_period_i)
  );

  // predictor state: one last-use stamp per {set, way}
  logic [NOW_W-1:0]    stamp_mem [0:SETS_DEF*WAYS_DEF-1];
  logic [PERIOD_W-1:0] residue_q;
  logic [PERIOD_W-1:0] period_q;
  logic [WAY_W-1:0]    victim_expect_q [$];
  logic [WAY_W-1:0]    expected_way;
  int unsigned         error_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL bimodal_insertion_replacement_core");
    $finish;
  end

  function automatic logic [WAY_W-1:0] oldest_way(input logic [SET_W-1:0] set_idx);
    logic [WAY_W-1:0] best;
    best = '0;
    for (int w = 1; w < WAYS_DEF; w++) begin
      if (stamp_mem[{set_idx, WAY_W'(w)}] < stamp_mem[{set_idx, best}]) best = WAY_W'(w);
    end
    return best;
  endfunction

  function automatic void apply_access(input opcode_e op, input logic [SET_W-1:0] set_idx,
                                       input logic [WAY_W-1:0] way, input logic hit,
                                       input logic [NOW_W-1:0] stamp);
    logic [NOW_W-1:0]    lru_stamp;
    logic [PERIOD_W:0]   next_residue;
    logic [PERIOD_W-1:0] eff_period;
    logic                mru;
    if (op == OPC_VICTIM) begin
      victim_expect_q.push_back(oldest_way(set_idx));
    end else begin
      // LRU insertion stamp is taken from the row before the write
      lru_stamp = stamp_mem[{set_idx, oldest_way(set_idx)}];
      lru_stamp = (lru_stamp != '0) ? lru_stamp - 1'b1 : '0;
      mru = hit;
      if (!hit) begin
        eff_period   = (period_q == '0) ? PERIOD_W'(1) : period_q;
        next_residue = {1'b0, residue_q} + 1'b1;
        if (next_residue >= {1'b0, eff_period}) begin
          residue_q = '0;
          mru       = 1'b1;
        end else begin
          residue_q = next_residue[PERIOD_W-1:0];
        end
      end
      stamp_mem[{set_idx, way}] = mru ? stamp : lru_stamp;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && victim_valid_o) begin
      if (victim_expect_q.size() == 0) begin
        $display("%0t: unexpected victim transfer, expected none, actual %0d",
                 $time, victim_way_o);
        error_count++;
      end else begin
        expected_way = victim_expect_q.pop_front();
        if (victim_way_o !== expected_way) begin
          $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                   $time, expected_way, victim_way_o);
          error_count++;
        end
      end
    end
  end

  // one transfer; returns right after the accepting edge with start dropped
  task automatic send_item(input opcode_e op, input logic [SET_W-1:0] set_idx,
                           input logic [WAY_W-1:0] way, input logic hit,
                           input logic [NOW_W-1:0] stamp);
    @(posedge clk_i);
    start       <= 1'b1;
    opcode_i    <= op;
    set_index_i <= set_idx;
    way_index_i <= way;
    was_hit_i   <= hit;
    now_i       <= stamp;
    do @(posedge clk_i); while (busy);
    apply_access(op, set_idx, way, hit, stamp);
    start <= 1'b0;
  endtask

  task automatic sender_gap(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  task automatic wait_block_idle();
    int unsigned guard;
    guard = 0;
    while ((victim_expect_q.size() != 0 || busy) && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $display("%0t: timeout waiting for idle, expected %0d pending, actual busy=%b",
               $time, victim_expect_q.size(), busy);
      error_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    wait_block_idle();
    insert_period_we_i <= 1'b1;
    insert_period_i    <= value;
    @(posedge clk_i);
    period_q = value;
    insert_period_we_i <= 1'b0;
  endtask

  // freshly cleared rows: every way ties, lowest wins
  task automatic test_reset_victims();
    send_item(OPC_VICTIM, '0, '0, 1'b0, '0);
    send_item(OPC_VICTIM, '1, '1, 1'b1, '1);
    send_item(OPC_VICTIM, 11'h555, 4'h5, 1'b0, 32'h5555_5555);
  endtask

  task automatic test_hit_stamps();
    send_item(OPC_UPDATE, 11'd5, 4'd0, 1'b1, '1);
    send_item(OPC_UPDATE, 11'd5, 4'd15, 1'b1, '0);
    send_item(OPC_VICTIM, 11'd5, 4'd0, 1'b0, '0);
    send_item(OPC_UPDATE, 11'd5, 4'd1, 1'b1, 32'd1);
    send_item(OPC_VICTIM, 11'd5, 4'd0, 1'b0, '0);
  endtask

  // misses under the reset period insert at LRU, floored at zero
  task automatic test_lru_insertion();
    send_item(OPC_UPDATE, 11'd5, 4'd2, 1'b0, 32'd50);
    send_item(OPC_VICTIM, 11'd5, 4'd0, 1'b0, '0);
    send_item(OPC_UPDATE, 11'd5, 4'd0, 1'b0, 32'd60);
    send_item(OPC_VICTIM, 11'd5, 4'd0, 1'b0, '0);
  endtask

  // residue already at the new period: next miss wraps to MRU
  task automatic test_period_below_residue();
    write_period(8'd2);
    send_item(OPC_UPDATE, 11'd5, 4'd3, 1'b0, 32'd77);
    send_item(OPC_VICTIM, 11'd5, 4'd0, 1'b0, '0);
  endtask

  task automatic test_period_extremes();
    write_period(8'd0);
    send_item(OPC_UPDATE, 11'd2047, 4'd4, 1'b0, 32'hFFFF_FFFE);
    send_item(OPC_UPDATE, 11'd2047, 4'd0, 1'b0, 32'd89);
    send_item(OPC_VICTIM, 11'd2047, 4'd0, 1'b0, '0);
    write_period(8'd1);
    send_item(OPC_UPDATE, 11'd2047, 4'd1, 1'b0, 32'd90);
    write_period(8'd255);
    send_item(OPC_UPDATE, 11'd2047, 4'd4, 1'b0, 32'd91);
    send_item(OPC_UPDATE, 11'd2047, 4'd2, 1'b0, 32'd92);
    send_item(OPC_VICTIM, 11'd2047, 4'd0, 1'b0, '0);
  endtask

  // mostly a few hot sets with rising time so rows fill and LRU stamps go nonzero
  task automatic test_random_traffic(input logic [PERIOD_W-1:0] period,
                                     input int unsigned items, input int unsigned idle_pct,
                                     input logic [NOW_W-1:0] time_base, input bit pause_midway);
    logic [SET_W-1:0] hot_sets [HOT_SETS];
    logic [NOW_W-1:0] clock_now;
    logic [NOW_W-1:0] stamp;
    logic [SET_W-1:0] set_idx;
    opcode_e          op;
    logic             hit;
    write_period(period);
    clock_now = time_base;
    foreach (hot_sets[k]) hot_sets[k] = SET_W'($urandom);
    for (int unsigned i = 0; i < items; i++) begin
      set_idx = ($urandom_range(99) < 80) ? hot_sets[$urandom_range(HOT_SETS - 1)]
                                          : SET_W'($urandom);
      op = ($urandom_range(99) < 35) ? OPC_VICTIM : OPC_UPDATE;
      hit = 1'($urandom_range(1));
      clock_now += $urandom_range(1, 40);
      stamp = ($urandom_range(99) < 5) ? NOW_W'($urandom) : clock_now;
      send_item(op, set_idx, WAY_W'($urandom), hit, stamp);
      sender_gap(idle_pct);
      if (pause_midway && i == items / 2) wait_block_idle();
    end
  endtask

  initial begin
    error_count        = 0;
    rst_ni             = 1'b0;
    start              = 1'b0;
    opcode_i           = OPC_VICTIM;
    set_index_i        = '0;
    way_index_i        = '0;
    was_hit_i          = 1'b0;
    now_i              = '0;
    insert_period_we_i = 1'b0;
    insert_period_i    = '0;
    for (int i = 0; i < SETS_DEF * WAYS_DEF; i++) stamp_mem[i] = '0;
    residue_q = '0;
    period_q  = PERIOD_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_victims();
    test_hit_stamps();
    test_lru_insertion();
    test_period_below_residue();
    test_period_extremes();
    test_random_traffic(8'd4, 350, 0, 32'd1000, 1'b0);
    test_random_traffic(8'd255, 300, 50, 32'd0, 1'b1);
    test_random_traffic(8'd1, 250, 26, 32'hFFFF_F000, 1'b0);
    test_random_traffic(PERIOD_W'($urandom_range(1, 255)), 350, 50, 32'd5000, 1'b0);
    test_random_traffic(8'd0, 100, 0, 32'h8000_0000, 1'b0);
    test_random_traffic(PERIOD_W'($urandom_range(2, 12)), 300, 26, 32'd20000, 1'b0);

    wait_block_idle();
    if (error_count == 0) begin
      $display("PASS bimodal_insertion_replacement_core");
    end else begin
      $display("FAIL bimodal_insertion_replacement_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bip_pkg.sv
rtl/bip_min_tree.sv
rtl/bimodal_insertion_replacement_core.sv
dv/bimodal_insertion_replacement_core_tb.sv
